[hdl/wss_pkg.sv]
`default_nettype none

package wss_pkg;

    // Fixed field widths of the sample and result channels.
    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 7;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int SUM_W    = SAMPLE_W + CNT_W;
    localparam int SQ_W     = 2 * SAMPLE_W;
    localparam int SUMSQ_W  = SQ_W + CNT_W;
    localparam int NUM_W    = SUMSQ_W + CNT_W;
    localparam int DEN_W    = 2 * CNT_W;
    localparam int ROOT_W   = NUM_W / 2;

    localparam int DEF_STORE_DEPTH = 64;

    localparam logic [CNT_W-1:0] WL_RESET = 7'd64;

    // Command codes of the input channel.
    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_POP     = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    // Divider operand selection.
    localparam logic [1:0] DIV_MEAN  = 2'd0;
    localparam logic [1:0] DIV_SLOPE = 2'd1;
    localparam logic [1:0] DIV_VAR   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;
        logic       walk_start;
        logic       prep;
        logic       vsub;
        logic       div_start;
        logic [1:0] div_sel;
        logic       mean_cap;
        logic       slope_cap;
        logic       sqrt_start;
        logic       load_result;
        logic       result_feat;
    } wss_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_long;
        logic walk_done;
        logic div_done;
        logic sqrt_done;
    } wss_status_t;

endpackage

`default_nettype wire

[hdl/windowed_signal_statistics.sv]
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-----------------------------------------
// s_        | in        | s_valid / s_ready  | command, sample_value, drop_count
// m_        | out       | m_valid / m_ready  | mean, std_dev, min, max, slope, fill, full
// cfg_      | in        | cfg_wr_en          | window_length (write resets the window)
//
// Push, pop and short compute items load the result at their transfer; the result is registered.
// A compute over N >= 2 samples walks the window through the sample RAM read port,
// then runs 23 + 17 + 46 divider steps and 23 square root steps, with a handoff
// between the units, and then loads the result.
// Reset (synchronous, active low) empties the window and sets the length to 64.
// A stalled result holds the output register; a new item waits until it is free.
`default_nettype none

module windowed_signal_statistics
    import wss_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        cfg_wr_en,
    input  wire  [CNT_W-1:0]           cfg_wr_data,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire  [1:0]                 s_command,
    input  wire  signed [SAMPLE_W-1:0] s_sample_value,
    input  wire  [CNT_W-1:0]           s_drop_count,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic signed [SAMPLE_W-1:0] m_mean_value,
    output logic [SAMPLE_W-1:0]        m_std_dev,
    output logic signed [SAMPLE_W-1:0] m_min_value,
    output logic signed [SAMPLE_W-1:0] m_max_value,
    output logic signed [DIFF_W-1:0]   m_slope_value,
    output logic [CNT_W-1:0]           m_fill_level,
    output logic                       m_window_full
);

    wss_cmd_t    cmd;
    wss_status_t status;

    // Sequencer for the multi-cycle compute.
    wss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Window store, accumulators, divider, square root and result register.
    wss_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_command      (s_command),
        .s_sample_value (s_sample_value),
        .s_drop_count   (s_drop_count),
        .cmd            (cmd),
        .status         (status),
        .m_mean_value   (m_mean_value),
        .m_std_dev      (m_std_dev),
        .m_min_value    (m_min_value),
        .m_max_value    (m_max_value),
        .m_slope_value  (m_slope_value),
        .m_fill_level   (m_fill_level),
        .m_window_full  (m_window_full)
    );

endmodule

`default_nettype wire

[hdl/wss_ram.sv]
`default_nettype none

module wss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire                       aclk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]   waddr,
    input  wire [WIDTH-1:0]           wdata,
    input  wire [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/wss_datapath.sv]
`default_nettype none

module wss_datapath
    import wss_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        cfg_wr_en,
    input  wire  [CNT_W-1:0]           cfg_wr_data,
    input  wire  [1:0]                 s_command,
    input  wire  signed [SAMPLE_W-1:0] s_sample_value,
    input  wire  [CNT_W-1:0]           s_drop_count,
    input  wss_cmd_t                   cmd,
    output wss_status_t                status,
    output logic signed [SAMPLE_W-1:0] m_mean_value,
    output logic [SAMPLE_W-1:0]        m_std_dev,
    output logic signed [SAMPLE_W-1:0] m_min_value,
    output logic signed [SAMPLE_W-1:0] m_max_value,
    output logic signed [DIFF_W-1:0]   m_slope_value,
    output logic [CNT_W-1:0]           m_fill_level,
    output logic                       m_window_full
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CMP_W  = (ADDR_W + 1 > CNT_W) ? ADDR_W + 1 : CNT_W;
    localparam int DCNT_W = $clog2(NUM_W + 1);
    localparam int RCNT_W = $clog2(ROOT_W + 1);

    // Window state.
    logic [CNT_W-1:0]  wl_reg;
    logic [CNT_W-1:0]  held_reg;
    logic [CNT_W-1:0]  held_next;
    logic [ADDR_W-1:0] wp_reg;
    logic [CMP_W-1:0]  len_eff;
    logic [CMP_W-1:0]  wp_inc;
    logic [ADDR_W-1:0] wp_wrap;
    logic [CMP_W:0]    old_sum;
    logic [CMP_W:0]    old_mod;
    logic [ADDR_W-1:0] oldest;

    // Walk over the window.
    logic              walk_run_reg;
    logic [ADDR_W-1:0] rd_pos_reg;
    logic [CMP_W-1:0]  rd_inc;
    logic [CNT_W-1:0]  rd_left_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              first_reg;
    logic              walk_done_reg;
    logic [SAMPLE_W-1:0]        rdata;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SQ_W-1:0]     prod;
    logic [SQ_W-1:0]            sq_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [SUMSQ_W-1:0]         sumsq_reg;
    logic signed [SAMPLE_W-1:0] min_reg;
    logic signed [SAMPLE_W-1:0] max_reg;
    logic signed [SAMPLE_W-1:0] first_val_reg;
    logic signed [SAMPLE_W-1:0] last_val_reg;

    // Variance operands.
    logic [SUM_W-1:0]  abs_sum;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] abs_diff;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  ssq_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  var_num_reg;

    // Shared divider.
    logic [NUM_W-1:0]  div_q_reg;
    logic [DEN_W-1:0]  div_r_reg;
    logic [DEN_W-1:0]  div_d_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic              div_done_reg;
    logic [DEN_W:0]    rem_sh;
    logic              rem_ge;
    logic [DEN_W:0]    rem_sub;

    // Square root unit.
    logic [NUM_W-1:0]  sq_v_reg;
    logic [NUM_W-1:0]  sq_res_reg;
    logic [NUM_W-1:0]  sq_bit_reg;
    logic [RCNT_W-1:0] sq_cnt_reg;
    logic              sqrt_done_reg;
    logic [NUM_W-1:0]  sq_t;

    // Captured features.
    logic signed [SAMPLE_W-1:0] mean_reg;
    logic signed [DIFF_W-1:0]   slope_reg;
    logic [SAMPLE_W-1:0]        std_val;
    logic [CNT_W-1:0]           fill_src;

    // Effective window length: zero acts as one, oversize clamps to the store.
    always_comb begin
        if (wl_reg == '0) begin
            len_eff = CMP_W'(1);
        end else if (CMP_W'(wl_reg) > CMP_W'(STORE_DEPTH)) begin
            len_eff = CMP_W'(STORE_DEPTH);
        end else begin
            len_eff = CMP_W'(wl_reg);
        end
    end

    // Circular position arithmetic.
    always_comb begin
        wp_inc  = CMP_W'(wp_reg) + CMP_W'(1);
        wp_wrap = (wp_inc == len_eff) ? '0 : wp_inc[ADDR_W-1:0];
        old_sum = {1'b0, CMP_W'(wp_reg)} + {1'b0, len_eff} - {1'b0, CMP_W'(held_reg)};
        old_mod = (old_sum >= {1'b0, len_eff}) ? old_sum - {1'b0, len_eff} : old_sum;
        oldest  = old_mod[ADDR_W-1:0];
        rd_inc  = CMP_W'(rd_pos_reg) + CMP_W'(1);
    end

    // Fill count after the current item.
    always_comb begin
        held_next = held_reg;
        unique case (s_command)
            OP_PUSH: begin
                if (CMP_W'(held_reg) < len_eff) begin
                    held_next = held_reg + CNT_W'(1);
                end
            end
            OP_POP: begin
                if (s_drop_count != '0) begin
                    held_next = (s_drop_count >= held_reg) ? '0 : held_reg - s_drop_count;
                end
            end
            default: begin
                held_next = held_reg;
            end
        endcase
    end

    // Window length, fill count and write position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg   <= WL_RESET;
            held_reg <= '0;
            wp_reg   <= '0;
        end else if (cfg_wr_en) begin
            wl_reg   <= cfg_wr_data;
            held_reg <= '0;
            wp_reg   <= '0;
        end else if (cmd.accept) begin
            held_reg <= held_next;
            if (s_command == OP_PUSH) begin
                wp_reg <= wp_wrap;
            end
        end
    end

    wss_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.accept && (s_command == OP_PUSH)),
        .waddr (wp_reg),
        .wdata (s_sample_value),
        .raddr (rd_pos_reg),
        .rdata (rdata)
    );

    assign x    = $signed(rdata);
    assign prod = x * x;

    // Walk control: one read issued per cycle, two stages behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_run_reg  <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            walk_done_reg <= 1'b0;
            rd_left_reg   <= '0;
            rd_pos_reg    <= '0;
            first_reg     <= 1'b0;
        end else begin
            walk_done_reg <= 1'b0;
            v2_reg        <= v1_reg;
            v1_reg        <= 1'b0;
            if (cmd.walk_start) begin
                walk_run_reg <= 1'b1;
                rd_pos_reg   <= oldest;
                rd_left_reg  <= held_reg;
                first_reg    <= 1'b1;
            end else if (walk_run_reg) begin
                if (rd_left_reg != '0) begin
                    rd_pos_reg  <= (rd_inc == len_eff) ? '0 : rd_inc[ADDR_W-1:0];
                    rd_left_reg <= rd_left_reg - CNT_W'(1);
                    v1_reg      <= 1'b1;
                end else if (!v1_reg && !v2_reg) begin
                    walk_run_reg  <= 1'b0;
                    walk_done_reg <= 1'b1;
                end
            end
            if (v1_reg) begin
                first_reg <= 1'b0;
            end
        end
    end

    // Accumulators for sum, sum of squares and the extremes.
    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end else begin
            if (v1_reg) begin
                sq_reg       <= unsigned'(prod);
                sum_reg      <= sum_reg + SUM_W'(x);
                last_val_reg <= x;
                if (first_reg) begin
                    first_val_reg <= x;
                    min_reg       <= x;
                    max_reg       <= x;
                end else begin
                    if (x < min_reg) begin
                        min_reg <= x;
                    end
                    if (x > max_reg) begin
                        max_reg <= x;
                    end
                end
            end
            if (v2_reg) begin
                sumsq_reg <= sumsq_reg + SUMSQ_W'(sq_reg);
            end
        end
    end

    assign abs_sum  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign diff     = DIFF_W'(last_val_reg) - DIFF_W'(first_val_reg);
    assign abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // Variance numerator and denominator: products first, then the difference.
    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            num_reg <= NUM_W'(held_reg) * NUM_W'(sumsq_reg);
            ssq_reg <= NUM_W'(abs_sum) * NUM_W'(abs_sum);
            den_reg <= DEN_W'(held_reg) * DEN_W'(held_reg - CNT_W'(1));
        end
        if (cmd.vsub) begin
            var_num_reg <= (num_reg >= ssq_reg) ? num_reg - ssq_reg : '0;
        end
    end

    // Restoring divider, one quotient bit per cycle.
    always_comb begin
        rem_sh  = {div_r_reg, div_q_reg[NUM_W-1]};
        rem_ge  = rem_sh >= {1'b0, div_d_reg};
        rem_sub = rem_sh - {1'b0, div_d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg  <= '0;
            div_done_reg <= 1'b0;
        end else begin
            div_done_reg <= 1'b0;
            if (cmd.div_start) begin
                div_r_reg <= '0;
                unique case (cmd.div_sel)
                    DIV_MEAN: begin
                        div_q_reg   <= {abs_sum, (NUM_W - SUM_W)'(0)};
                        div_d_reg   <= DEN_W'(held_reg);
                        div_cnt_reg <= DCNT_W'(SUM_W);
                    end
                    DIV_SLOPE: begin
                        div_q_reg   <= {abs_diff, (NUM_W - DIFF_W)'(0)};
                        div_d_reg   <= DEN_W'(held_reg - CNT_W'(1));
                        div_cnt_reg <= DCNT_W'(DIFF_W);
                    end
                    default: begin
                        div_q_reg   <= var_num_reg;
                        div_d_reg   <= den_reg;
                        div_cnt_reg <= DCNT_W'(NUM_W);
                    end
                endcase
            end else if (div_cnt_reg != '0) begin
                div_r_reg   <= rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                div_q_reg   <= {div_q_reg[NUM_W-2:0], rem_ge};
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
                if (div_cnt_reg == DCNT_W'(1)) begin
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    // Capture of mean and slope, truncated toward zero.
    always_ff @(posedge aclk) begin
        if (cmd.mean_cap) begin
            mean_reg <= sum_reg[SUM_W-1] ? -$signed(div_q_reg[SAMPLE_W-1:0])
                                         : $signed(div_q_reg[SAMPLE_W-1:0]);
        end
        if (cmd.slope_cap) begin
            slope_reg <= diff[DIFF_W-1] ? -$signed(div_q_reg[DIFF_W-1:0])
                                        : $signed(div_q_reg[DIFF_W-1:0]);
        end
    end

    // Bitwise square root, two radicand bits per cycle.
    assign sq_t = sq_res_reg + sq_bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_cnt_reg    <= '0;
            sqrt_done_reg <= 1'b0;
        end else begin
            sqrt_done_reg <= 1'b0;
            if (cmd.sqrt_start) begin
                sq_v_reg   <= div_q_reg;
                sq_res_reg <= '0;
                sq_bit_reg <= NUM_W'(1) << (NUM_W - 2);
                sq_cnt_reg <= RCNT_W'(ROOT_W);
            end else if (sq_cnt_reg != '0) begin
                if (sq_v_reg >= sq_t) begin
                    sq_v_reg   <= sq_v_reg - sq_t;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                sq_cnt_reg <= sq_cnt_reg - RCNT_W'(1);
                if (sq_cnt_reg == RCNT_W'(1)) begin
                    sqrt_done_reg <= 1'b1;
                end
            end
        end
    end

    assign std_val = (sq_res_reg > NUM_W'({SAMPLE_W{1'b1}})) ? {SAMPLE_W{1'b1}}
                                                           : sq_res_reg[SAMPLE_W-1:0];

    // Result register.
    assign fill_src = cmd.accept ? held_next : held_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            m_fill_level  <= fill_src;
            m_window_full <= CMP_W'(fill_src) >= len_eff;
            if (cmd.result_feat) begin
                m_mean_value  <= mean_reg;
                m_std_dev     <= std_val;
                m_min_value   <= min_reg;
                m_max_value   <= max_reg;
                m_slope_value <= slope_reg;
            end else begin
                m_mean_value  <= '0;
                m_std_dev     <= '0;
                m_min_value   <= '0;
                m_max_value   <= '0;
                m_slope_value <= '0;
            end
        end
    end

    assign status.in_long   = (s_command == OP_COMPUTE) && (held_reg > CNT_W'(1));
    assign status.walk_done = walk_done_reg;
    assign status.div_done  = div_done_reg;
    assign status.sqrt_done = sqrt_done_reg;

    // The fill count never exceeds the window, and the write position stays inside it.
    a_held_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(held_reg) <= len_eff)
        else $error("fill count beyond window length");

    a_wp_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(wp_reg) < len_eff)
        else $error("write position outside window");

endmodule

`default_nettype wire

[hdl/wss_ctrl.sv]
`default_nettype none

module wss_ctrl
    import wss_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  wire         m_ready,
    input  wss_status_t status,
    output wss_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_WALK   = 4'd1;
    localparam logic [3:0] ST_DMEAN  = 4'd2;
    localparam logic [3:0] ST_DSLOPE = 4'd3;
    localparam logic [3:0] ST_DVAR   = 4'd4;
    localparam logic [3:0] ST_SQRT   = 4'd5;
    localparam logic [3:0] ST_DONE   = 4'd6;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       m_valid_reg;
    logic       out_free;

    // The result slot is free when empty or being taken in this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign m_valid  = m_valid_reg;

    // Sequencing of one compute: walk, three divisions, square root.
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && out_free) begin
                    cmd.accept = 1'b1;
                    if (status.in_long) begin
                        cmd.walk_start = 1'b1;
                        state_next     = ST_WALK;
                    end else begin
                        cmd.load_result = 1'b1;
                    end
                end
            end
            ST_WALK: begin
                if (status.walk_done) begin
                    cmd.prep      = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_MEAN;
                    state_next    = ST_DMEAN;
                end
            end
            ST_DMEAN: begin
                if (status.div_done) begin
                    cmd.mean_cap  = 1'b1;
                    cmd.vsub      = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SLOPE;
                    state_next    = ST_DSLOPE;
                end
            end
            ST_DSLOPE: begin
                if (status.div_done) begin
                    cmd.slope_cap = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_VAR;
                    state_next    = ST_DVAR;
                end
            end
            ST_DVAR: begin
                if (status.div_done) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (status.sqrt_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_result = 1'b1;
                    cmd.result_feat = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    a_long_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && status.in_long |=> state_reg == ST_WALK)
        else $error("compute transfer did not start the walk");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == ST_DMEAN || state_reg == ST_DSLOPE
                             || state_reg == ST_DVAR))
        else $error("divider finished outside a divide step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import wss_pkg::*;

    // Input item and expected result records.
    typedef struct {
        logic [1:0]                 command;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [CNT_W-1:0]           drop_count;
    } stat_item_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] mean_value;
        logic [SAMPLE_W-1:0]        std_dev;
        logic signed [SAMPLE_W-1:0] min_value;
        logic signed [SAMPLE_W-1:0] max_value;
        logic signed [DIFF_W-1:0]   slope_value;
        logic [CNT_W-1:0]           fill_level;
        logic                       window_full;
    } stat_result_t;

    localparam int DEPTH       = DEF_STORE_DEPTH;
    localparam int CYCLE_LIMIT = 2000000;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]           cfg_wr_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_command = OP_PUSH;
    logic signed [SAMPLE_W-1:0] s_sample_value = '0;
    logic [CNT_W-1:0]           s_drop_count = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_mean_value;
    logic [SAMPLE_W-1:0]        m_std_dev;
    logic signed [SAMPLE_W-1:0] m_min_value;
    logic signed [SAMPLE_W-1:0] m_max_value;
    logic signed [DIFF_W-1:0]   m_slope_value;
    logic [CNT_W-1:0]           m_fill_level;
    logic                       m_window_full;

    windowed_signal_statistics i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_sample_value(s_sample_value),
        .s_drop_count  (s_drop_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mean_value  (m_mean_value),
        .m_std_dev     (m_std_dev),
        .m_min_value   (m_min_value),
        .m_max_value   (m_max_value),
        .m_slope_value (m_slope_value),
        .m_fill_level  (m_fill_level),
        .m_window_full (m_window_full)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    stat_item_t   pending_items[$];
    stat_result_t expected_stats[$];
    int           error_count = 0;
    int           result_count = 0;
    bit           calm = 1'b0;

    // Predictor state.
    logic signed [SAMPLE_W-1:0] win_store[DEPTH];
    int unsigned                win_wpos = 0;
    int unsigned                win_count = 0;
    logic [CNT_W-1:0]           win_length = WL_RESET;

    initial begin
        for (int i = 0; i < DEPTH; i++) win_store[i] = '0;
    end

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint sample_at(int unsigned len, int unsigned idx);
        int unsigned oldest;
        oldest = (win_wpos + len - (win_count % (len + 1))) % len;
        return longint'(win_store[(oldest + idx) % len]);
    endfunction

    // Applies one item to the predictor state and returns its result.
    task automatic predict_stats(input stat_item_t it, output stat_result_t r);
        int unsigned     len;
        int unsigned     n;
        longint          x, sum, mean, mn, mx, slope;
        longint unsigned sumsq, ssum, num, den, sd;
        len = (win_length == 0) ? 1 : ((win_length > DEPTH) ? DEPTH : win_length);
        mean = 0; mn = 0; mx = 0; slope = 0; sd = 0;
        if (win_count > len) win_count = len;
        if (win_wpos >= len) win_wpos = 0;
        if (it.command == OP_PUSH) begin
            win_store[win_wpos] = it.sample_value;
            win_wpos = (win_wpos + 1) % len;
            if (win_count < len) win_count++;
        end else if (it.command == OP_POP) begin
            if (it.drop_count != 0) begin
                if (it.drop_count >= win_count) win_count = 0;
                else win_count = win_count - it.drop_count;
            end
        end else if (it.command == OP_COMPUTE && win_count > 1) begin
            n = win_count;
            sum = 0;
            sumsq = 0;
            mn = sample_at(len, 0);
            mx = mn;
            for (int unsigned i = 0; i < n; i++) begin
                x = sample_at(len, i);
                sum += x;
                sumsq += longint'(x * x);
                if (x < mn) mn = x;
                if (x > mx) mx = x;
            end
            mean = sum / longint'(n);
            ssum = (sum < 0) ? -sum : sum;
            ssum = ssum * ssum;
            num = longint'(n) * sumsq;
            num = (num >= ssum) ? num - ssum : 0;
            den = longint'(n) * longint'(n - 1);
            sd = floor_root(num / den);
            if (sd > 65535) sd = 65535;
            slope = (sample_at(len, n - 1) - sample_at(len, 0)) / longint'(n - 1);
        end
        r.mean_value  = mean[SAMPLE_W-1:0];
        r.std_dev     = sd[SAMPLE_W-1:0];
        r.min_value   = mn[SAMPLE_W-1:0];
        r.max_value   = mx[SAMPLE_W-1:0];
        r.slope_value = slope[DIFF_W-1:0];
        r.fill_level  = win_count[CNT_W-1:0];
        r.window_full = (win_count >= len);
    endtask

    // Driver: offers pending items and predicts each accepted transfer.
    int drv_gap = 0;
    int accepted_count = 0;
    always @(posedge aclk) begin
        stat_item_t   it;
        stat_result_t r;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                it.command = s_command;
                it.sample_value = s_sample_value;
                it.drop_count = s_drop_count;
                predict_stats(it, r);
                expected_stats.push_back(r);
                accepted_count++;
            end
            if (s_valid && !s_ready) begin
                // Hold the offered item until it is taken.
            end else if (drv_gap > 0) begin
                drv_gap <= drv_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                s_valid <= 1'b1;
                s_command <= it.command;
                s_sample_value <= it.sample_value;
                s_drop_count <= it.drop_count;
                if (!calm && $urandom_range(0, 3) == 0) drv_gap <= $urandom_range(1, 5);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input longint e, input longint a);
        if (e != a) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
            error_count++;
        end
    endtask

    // Monitor: random backpressure, one long hold-off, and result checks.
    int  rdy_gap = 0;
    int  hold_off = 0;
    bit  hold_done = 1'b0;
    always @(posedge aclk) begin
        stat_result_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual fill %0d",
                             $time, m_fill_level);
                    error_count++;
                end else begin
                    e = expected_stats.pop_front();
                    check_field("mean_value", e.mean_value, m_mean_value);
                    check_field("std_dev", e.std_dev, m_std_dev);
                    check_field("min_value", e.min_value, m_min_value);
                    check_field("max_value", e.max_value, m_max_value);
                    check_field("slope_value", e.slope_value, m_slope_value);
                    check_field("fill_level", e.fill_level, m_fill_level);
                    check_field("window_full", e.window_full, m_window_full);
                end
            end
            if (!hold_done && result_count == 300) begin
                hold_done <= 1'b1;
                hold_off <= 3000;
                m_ready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else if (rdy_gap > 0) begin
                rdy_gap <= rdy_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 4) == 0) rdy_gap <= $urandom_range(1, 5);
            end
        end
    end

    // Run limit.
    int cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_item(input logic [1:0] c, input logic [15:0] v, input logic [6:0] d);
        stat_item_t it;
        it.command = c;
        it.sample_value = v;
        it.drop_count = d;
        pending_items.push_back(it);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_valid || expected_stats.size() > 0)
            @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    task automatic write_length(input logic [6:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        win_length = v;
        win_count = 0;
        win_wpos = 0;
        @(posedge aclk);
    endtask

    // Stimulus phases.
    logic [6:0] lengths[8] = '{7'd1, 7'd2, 7'd0, 7'd127, 7'd65, 7'd5, 7'd64, 7'd17};
    initial begin
        int per_phase;
        int k;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset length.
        add_item(OP_COMPUTE, 16'h0, 7'd0);
        add_item(OP_PUSH, 16'h7FFF, 7'd0);
        add_item(OP_COMPUTE, 16'h0, 7'd0);
        add_item(OP_PUSH, 16'h8000, 7'd127);
        add_item(OP_COMPUTE, 16'hFFFF, 7'd0);
        add_item(OP_PUSH, 16'h7FFF, 7'd0);
        add_item(OP_PUSH, 16'h8000, 7'd0);
        add_item(OP_COMPUTE, 16'h0, 7'd0);
        add_item(2'd3, 16'h1234, 7'd5);
        add_item(OP_POP, 16'h0, 7'd0);
        add_item(OP_POP, 16'h0, 7'd1);
        add_item(OP_COMPUTE, 16'h0, 7'd0);
        add_item(OP_POP, 16'hFFFF, 7'd127);
        add_item(OP_COMPUTE, 16'h0, 7'd0);
        for (int i = 0; i < 66; i++) add_item(OP_PUSH, 16'(i * 517 - 9000), 7'd0);
        add_item(OP_COMPUTE, 16'h0, 7'd0);
        add_item(OP_POP, 16'h0, 7'd64);
        add_item(OP_COMPUTE, 16'h0, 7'd0);
        wait_idle();

        // Random part over several window lengths.
        per_phase = 1850 / 9;
        for (int p = 0; p < 9; p++) begin
            write_length(p < 8 ? lengths[p] : 7'($urandom_range(1, 127)));
            if (p == 8) calm = 1'b1;
            k = 0;
            while (k < per_phase) begin
                if ($urandom_range(0, 9) < 8) begin
                    // Fill burst followed by a compute.
                    repeat ($urandom_range(1, 20)) begin
                        add_item(OP_PUSH, pick_sample(), 7'($urandom()));
                        k++;
                    end
                    add_item(OP_COMPUTE, 16'($urandom()), 7'($urandom()));
                    k++;
                end else begin
                    case ($urandom_range(0, 3))
                        0: add_item(2'd3, 16'($urandom()), 7'($urandom()));
                        1: add_item(OP_POP, 16'($urandom()), 7'($urandom()));
                        default: add_item(OP_POP, 16'($urandom()), 7'($urandom_range(0, 4)));
                    endcase
                    k++;
                end
            end
            wait_idle();
        end

        repeat (200) @(posedge aclk);
        if (error_count == 0 && expected_stats.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
